// ===== rtl/swta_pkg.sv =====
// ----------------------------------------------------------------------------
// swta_pkg
// Types, constants and the control store for the sorted window trim average.
// ----------------------------------------------------------------------------
package swta_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned KEEP_W     = 4;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 4'd8;

  // Step counter of the sequencer
  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_COLLECT = 4'd0;  // take samples into the store
  localparam step_t S_RD_A    = 4'd1;  // read the outer sort position
  localparam step_t S_LD_CUR  = 4'd2;  // hold v[a], read v[b]
  localparam step_t S_CMP     = 4'd3;  // compare and exchange, read next b
  localparam step_t S_WR_A    = 4'd4;  // write back the minimum, advance a
  localparam step_t S_RD_FST  = 4'd5;  // read the first kept entry
  localparam step_t S_LD_ACC  = 4'd6;  // seed the accumulator
  localparam step_t S_FOLD    = 4'd7;  // pairwise average over the rest
  localparam step_t S_EMIT    = 4'd8;  // hand the result to the output

  typedef enum logic [1:0] {
    RD_A,
    RD_B,
    RD_B_NEXT,
    RD_FIRST
  } rd_sel_t;

  typedef enum logic [1:0] {
    B_HOLD,
    B_LOAD_A1,
    B_LOAD_F1,
    B_INC
  } b_op_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_FOLD
  } acc_op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_LAST_IN,
    C_B_MORE,
    C_A_MORE,
    C_KEEP_ONE,
    C_OUT_FREE
  } cond_t;

  // One control word: datapath strobes, then branch control
  typedef struct packed {
    logic    in_rdy;
    logic    a_clr;
    logic    a_inc;
    logic    cur_ld;
    logic    cmp_swap;
    logic    wr_a;
    logic    emit;
    rd_sel_t rd_sel;
    b_op_t   b_op;
    acc_op_t acc_op;
    cond_t   cond;
    logic    hold;    // stay on this step while the condition is false
    step_t   target;  // jump target when the condition is true
  } ctrl_word_t;

  // Control store
  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t w;
    w        = '0;
    w.rd_sel = RD_A;
    w.b_op   = B_HOLD;
    w.acc_op = ACC_HOLD;
    w.cond   = C_NONE;
    w.target = S_COLLECT;
    unique case (step)
      S_COLLECT: begin
        w.in_rdy = 1'b1;
        w.a_clr  = 1'b1;
        w.cond   = C_LAST_IN;
        w.hold   = 1'b1;
        w.target = S_RD_A;
      end
      S_RD_A: begin
        w.rd_sel = RD_A;
        w.b_op   = B_LOAD_A1;
      end
      S_LD_CUR: begin
        w.cur_ld = 1'b1;
        w.rd_sel = RD_B;
      end
      S_CMP: begin
        w.cmp_swap = 1'b1;
        w.rd_sel   = RD_B_NEXT;
        w.b_op     = B_INC;
        w.cond     = C_B_MORE;
        w.target   = S_CMP;
      end
      S_WR_A: begin
        w.wr_a   = 1'b1;
        w.a_inc  = 1'b1;
        w.cond   = C_A_MORE;
        w.target = S_RD_A;
      end
      S_RD_FST: begin
        w.rd_sel = RD_FIRST;
        w.b_op   = B_LOAD_F1;
      end
      S_LD_ACC: begin
        w.acc_op = ACC_LOAD;
        w.rd_sel = RD_B;
        w.cond   = C_KEEP_ONE;
        w.target = S_EMIT;
      end
      S_FOLD: begin
        w.acc_op = ACC_FOLD;
        w.rd_sel = RD_B_NEXT;
        w.b_op   = B_INC;
        w.cond   = C_B_MORE;
        w.target = S_FOLD;
      end
      S_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = C_OUT_FREE;
        w.hold   = 1'b1;
        w.target = S_COLLECT;
      end
      default: begin
        w.cond   = C_NONE;
        w.hold   = 1'b0;
        w.target = S_COLLECT;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/swta_ram.sv =====
// ----------------------------------------------------------------------------
// swta_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
module swta_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sorted_window_trim_average.sv =====
// Collecting takes one sample per cycle. After the last sample of a window the
// store is sorted in place by a selection exchange over the one read port,
// then the kept entries are folded while input is held off; input stays held
// off while a result waits on out_ready. Synchronous reset empties the window
// and sets keep to 8.
// ----------------------------------------------------------------------------
// sorted_window_trim_average
// Windowed sort and trimmed pairwise average of ADC samples, run by a
// microcoded sequencer over a sample store with one write and one read port.
// ----------------------------------------------------------------------------
module sorted_window_trim_average
  import swta_pkg::*;
#(
  parameter int unsigned WINDOW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [KEEP_W-1:0]   keep_count,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] filtered_value
);

  localparam int unsigned AW = $clog2(WINDOW);
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned KW = (CW > KEEP_W) ? CW : KEEP_W;

  localparam logic [CW-1:0] WIN_FULL  = CW'(WINDOW);
  localparam logic [CW-1:0] WIN_LAST  = CW'(WINDOW - 1);
  localparam logic [CW-1:0] WIN_LAST2 = CW'(WINDOW - 2);

  step_t             pc;
  step_t             pc_next;
  ctrl_word_t        cw;
  logic              cond_met;

  logic [KEEP_W-1:0] keep;
  logic [CW-1:0]     fill;
  logic [CW-1:0]     a;
  logic [CW-1:0]     b;
  logic [SAMPLE_W-1:0] cur;
  logic [SAMPLE_W-1:0] acc;

  logic [KW-1:0]     keep_ext;
  logic [CW-1:0]     keep_eff;
  logic [CW-1:0]     first;
  logic              b_more;
  logic              in_fire;
  logic              out_free;
  logic              swap;
  logic [SAMPLE_W:0] fold_sum;

  logic              ram_we;
  logic [CW-1:0]     ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [CW-1:0]     ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  // Decode the current step
  assign cw        = ucode(pc);
  assign in_ready  = cw.in_rdy;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign b_more    = (b != WIN_LAST);
  assign swap      = cw.cmp_swap && (cur > ram_rdata);
  assign fold_sum  = {1'b0, acc} + {1'b0, ram_rdata};

  // Clamp keep to 1..WINDOW, find the first kept sorted entry
  assign keep_ext = KW'(keep);
  always_comb begin
    if (keep == '0) begin
      keep_eff = CW'(1);
    end else if (keep_ext > KW'(WINDOW)) begin
      keep_eff = WIN_FULL;
    end else begin
      keep_eff = CW'(keep_ext);
    end
  end
  assign first = WIN_FULL - keep_eff;

  // Branch condition
  always_comb begin
    case (cw.cond)
      C_LAST_IN:  cond_met = in_fire && (fill == WIN_LAST);
      C_B_MORE:   cond_met = b_more;
      C_A_MORE:   cond_met = (a != WIN_LAST2);
      C_KEEP_ONE: cond_met = (b == WIN_FULL);
      C_OUT_FREE: cond_met = out_free;
      default:    cond_met = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    if (cond_met) begin
      pc_next = cw.target;
    end else if (cw.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + step_t'(1);
    end
  end

  // Store write port: incoming sample, exchange, or write back of minimum
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill;
    ram_wdata = sample;
    if (in_fire) begin
      ram_we = 1'b1;
    end else if (swap) begin
      ram_we    = 1'b1;
      ram_waddr = b;
      ram_wdata = cur;
    end else if (cw.wr_a) begin
      ram_we    = 1'b1;
      ram_waddr = a;
      ram_wdata = cur;
    end
  end

  // Store read address
  always_comb begin
    case (cw.rd_sel)
      RD_A:      ram_raddr = a;
      RD_B:      ram_raddr = b;
      RD_B_NEXT: ram_raddr = b_more ? (b + CW'(1)) : b;
      RD_FIRST:  ram_raddr = first;
      default:   ram_raddr = a;
    endcase
  end

  swta_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= S_COLLECT;
      fill      <= '0;
      keep      <= KEEP_RESET;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_valid && cfg_ready) begin
        keep <= keep_count;
      end
      if (in_fire) begin
        fill <= (fill == WIN_LAST) ? '0 : fill + CW'(1);
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cw.emit && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // sort indices
    if (cw.a_clr) begin
      a <= '0;
    end else if (cw.a_inc) begin
      a <= a + CW'(1);
    end
    case (cw.b_op)
      B_LOAD_A1: b <= a + CW'(1);
      B_LOAD_F1: b <= first + CW'(1);
      B_INC:     b <= b + CW'(1);
      default:   b <= b;
    endcase
    // running minimum of the exchange pass
    if (cw.cur_ld || swap) begin
      cur <= ram_rdata;
    end
    // pairwise average accumulator
    case (cw.acc_op)
      ACC_LOAD: acc <= ram_rdata;
      ACC_FOLD: acc <= fold_sum[SAMPLE_W:1];
      default:  acc <= acc;
    endcase
    // output register
    if (cw.emit && out_free) begin
      filtered_value <= acc;
    end
  end

endmodule

// ===== rtl/swta_checker.sv =====
// ----------------------------------------------------------------------------
// swta_checker
// Port-level checks on the sorted window trim average, bound to the top.
// ----------------------------------------------------------------------------
module swta_checker
  import swta_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] filtered_value
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_value))
    else $error("result changed while stalled");

  // A result never appears the cycle after an item is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result raised straight after an item");

  // A new result follows a cycle with input held off
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised while collecting");

endmodule

bind sorted_window_trim_average swta_checker u_checker (.*);
